@@ rtl/core/dpc_pkg.sv @@
// Shared types and constants for the depth pixel colorizer.
// Used by the top level and by the pipelined divider; depends on nothing.
package dpc_pkg;

  // Field widths fixed by the pixel and color formats.
  localparam int PIX_W        = 16;
  localparam int CH_W         = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int PIXEL_BITS_DEF = 16;

  // Scaled numerator 255 * n with n up to 16 bits.
  localparam int NUM_W = PIX_W + CH_W;

  // Rainbow distance f = 5 * v needs three more bits than the pixel.
  localparam int F_W = PIX_W + 3;

  // Distance limit for the point-valid flag and the top gray level.
  localparam logic [PIX_W-1:0] POINT_LIMIT = 16'd64000;
  localparam logic [PIX_W-1:0] GRAY_TOP    = 16'd255;

  // Reset values of the configuration registers.
  localparam logic [PIX_W-1:0] RANGE_MAX_RST = 16'd12500;
  localparam logic [PIX_W-1:0] OVF_CODE_RST  = 16'd65532;
  localparam logic [PIX_W-1:0] SAT_CODE_RST  = 16'd65534;
  localparam logic [PIX_W-1:0] INTF_CODE_RST = 16'd65533;
  localparam logic [PIX_W-1:0] LOW_CODE_RST  = 16'd65535;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MODE = 3'd0,
    REG_RANGE_MAX  = 3'd1,
    REG_OVF_CODE   = 3'd2,
    REG_SAT_CODE   = 3'd3,
    REG_INTF_CODE  = 3'd4,
    REG_LOW_CODE   = 3'd5
  } reg_idx_t;

  // Color mode values.
  localparam logic MODE_RAINBOW = 1'b0;
  localparam logic MODE_GRAY    = 1'b1;

  // Which channel, if any, takes the divider quotient.
  typedef enum logic [1:0] {
    SLOT_NONE  = 2'd0,
    SLOT_RED   = 2'd1,
    SLOT_GREEN = 2'd2,
    SLOT_BLUE  = 2'd3
  } slot_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // Fixed colors.
  localparam rgb_t RGB_OVF     = '{r: 8'd169, g: 8'd14,  b: 8'd255};
  localparam rgb_t RGB_SAT     = '{r: 8'd255, g: 8'd0,   b: 8'd128};
  localparam rgb_t RGB_BLACK   = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
  localparam rgb_t RGB_MAGENTA = '{r: 8'd255, g: 8'd0,   b: 8'd255};
  localparam rgb_t RGB_WHITE   = '{r: 8'd255, g: 8'd255, b: 8'd255};
  localparam rgb_t RGB_RED     = '{r: 8'd255, g: 8'd0,   b: 8'd0};
  localparam rgb_t RGB_GREEN   = '{r: 8'd0,   g: 8'd255, b: 8'd0};
  localparam rgb_t RGB_BLUE    = '{r: 8'd0,   g: 8'd0,   b: 8'd255};

  // Per-pixel information that rides alongside the division.
  typedef struct packed {
    slot_t slot;
    rgb_t  base;
    logic  pv;
  } dpc_side_t;

endpackage

@@ rtl/core/dpc_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on dpc_pkg for the sideband type carried along with each transfer.
module dpc_div_pipe #(
  parameter int NUM_W = dpc_pkg::NUM_W,
  parameter int DEN_W = dpc_pkg::PIX_W,
  parameter int Q_W   = dpc_pkg::CH_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_W-1:0]     in_num,
  input  logic [DEN_W-1:0]     in_den,
  input  dpc_pkg::dpc_side_t   in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [Q_W-1:0]       out_quo,
  output dpc_pkg::dpc_side_t   out_side
);
  import dpc_pkg::*;

  // The quotient must fit in Q_W bits: num < 2^Q_W * den.
  logic                stg_valid [Q_W];
  logic [NUM_W-1:0]    stg_rem   [Q_W];
  logic [Q_W-1:0]      stg_quo   [Q_W];
  logic [DEN_W-1:0]    stg_den   [Q_W];
  dpc_side_t           stg_side  [Q_W];

  logic                src_valid [Q_W];
  logic [NUM_W-1:0]    src_rem   [Q_W];
  logic [Q_W-1:0]      src_quo   [Q_W];
  logic [DEN_W-1:0]    src_den   [Q_W];
  dpc_side_t           src_side  [Q_W];

  logic                adv       [Q_W+1];

  assign adv[Q_W] = out_ready;
  assign in_ready = adv[0];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int BIT = Q_W - 1 - k;

    logic [NUM_W:0]   dsh;
    logic [NUM_W:0]   rem_ext;
    logic [NUM_W:0]   diff;
    logic             take;

    // Stage inputs come from the port for the first step.
    if (k == 0) begin : g_first
      assign src_valid[k] = in_valid;
      assign src_rem[k]   = in_num;
      assign src_quo[k]   = '0;
      assign src_den[k]   = in_den;
      assign src_side[k]  = in_side;
    end else begin : g_rest
      assign src_valid[k] = stg_valid[k-1];
      assign src_rem[k]   = stg_rem[k-1];
      assign src_quo[k]   = stg_quo[k-1];
      assign src_den[k]   = stg_den[k-1];
      assign src_side[k]  = stg_side[k-1];
    end

    // A stage moves when it is empty or its successor moves.
    assign adv[k] = !stg_valid[k] || adv[k+1];

    // Trial subtraction of the divisor shifted to this quotient bit.
    assign dsh     = {{(NUM_W + 1 - DEN_W){1'b0}}, src_den[k]} << BIT;
    assign rem_ext = {1'b0, src_rem[k]};
    assign diff    = rem_ext - dsh;
    assign take    = (rem_ext >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (adv[k]) begin
        stg_valid[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && src_valid[k]) begin
        stg_rem[k]  <= take ? diff[NUM_W-1:0] : src_rem[k];
        stg_quo[k]  <= {src_quo[k][Q_W-2:0], take};
        stg_den[k]  <= src_den[k];
        stg_side[k] <= src_side[k];
      end
    end
  end

  assign out_valid = stg_valid[Q_W-1];
  assign out_quo   = stg_quo[Q_W-1];
  assign out_side  = stg_side[Q_W-1];

endmodule

@@ rtl/core/depth_pixel_colorizer.sv @@
// Depth pixel colorizer top level: rainbow or grayscale color per pixel.
// Depends on dpc_pkg and on dpc_div_pipe for the channel ratio.
//
// Usage:
//   Pixels enter on in_valid / in_ready / pixel_value, one transfer per cycle.
//   Colors leave on out_valid / out_ready / red / green / blue / point_valid,
//   one result per pixel, in input order.
//   Configuration is written through cfg_we / cfg_index / cfg_data and takes
//   effect at once; write it only while no pixels are in flight.
//   Path: each input transfer is registered through capture, classify,
//   segment select, scale, 8 divider steps and output, in that order.
//   Throughput: one pixel per cycle while out_ready is held high. The
//   rainbow ratio 255*n/range_max is computed by an 8-stage divider, one
//   quotient bit per stage, which sets the pipeline depth but not the rate.
//   Stall: every stage holds while its successor is full and not moving;
//   empty stages keep filling, so nothing is lost or repeated.
//   Reset: all stages empty, registers at their reset values
//   (rainbow mode, range 12500, codes 65532 / 65534 / 65533 / 65535).
module depth_pixel_colorizer #(
  parameter int PIXEL_BITS = dpc_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dpc_pkg::PIX_W-1:0]       pixel_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dpc_pkg::CH_W-1:0]        red,
  output logic [dpc_pkg::CH_W-1:0]        green,
  output logic [dpc_pkg::CH_W-1:0]        blue,
  output logic                            point_valid,
  input  logic                            cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpc_pkg::PIX_W-1:0]       cfg_data
);
  import dpc_pkg::*;

  localparam logic [PIX_W-1:0] PIX_MASK =
    PIX_W'((({(PIX_W + 1){1'b0}} | 1) << PIXEL_BITS) - 1);

  // Configuration registers.
  logic             color_mode;
  logic [PIX_W-1:0] range_max;
  logic [PIX_W-1:0] ovf_code;
  logic [PIX_W-1:0] sat_code;
  logic [PIX_W-1:0] intf_code;
  logic [PIX_W-1:0] low_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_RAINBOW;
      range_max  <= RANGE_MAX_RST;
      ovf_code   <= OVF_CODE_RST;
      sat_code   <= SAT_CODE_RST;
      intf_code  <= INTF_CODE_RST;
      low_code   <= LOW_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_MODE: color_mode <= cfg_data[0];
        REG_RANGE_MAX:  range_max  <= cfg_data;
        REG_OVF_CODE:   ovf_code   <= cfg_data;
        REG_SAT_CODE:   sat_code   <= cfg_data;
        REG_INTF_CODE:  intf_code  <= cfg_data;
        REG_LOW_CODE:   low_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: each stage advances when empty or when drained.
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic a_adv, b_adv, c_adv, d_adv, e_adv;
  logic div_in_ready, div_out_valid;

  assign e_adv    = !e_valid || out_ready;
  assign d_adv    = !d_valid || div_in_ready;
  assign c_adv    = !c_valid || d_adv;
  assign b_adv    = !b_valid || c_adv;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= in_valid;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
      if (c_adv) begin
        c_valid <= b_valid;
      end
      if (d_adv) begin
        d_valid <= c_valid;
      end
      if (e_adv) begin
        e_valid <= div_out_valid;
      end
    end
  end

  // Stage A: capture the masked pixel.
  logic [PIX_W-1:0] a_pix;

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_pix <= pixel_value & PIX_MASK;
    end
  end

  // Stage B: code replacement, fixed colors, gray levels, point flag and 5 * v.
  dpc_side_t        b_side, b_side_next;
  logic [F_W-1:0]   b_f, b_f_next;

  always_comb begin
    logic [PIX_W-1:0] vd;
    vd          = a_pix;
    b_side_next = '{slot: SLOT_NONE, base: RGB_BLACK, pv: 1'b0};
    b_f_next    = '0;
    if (color_mode == MODE_RAINBOW) begin
      if (a_pix == low_code) begin
        vd = '0;
      end
      b_side_next.pv = (vd != '0) && (vd < POINT_LIMIT);
      b_f_next       = ({3'b000, vd} << 2) + {3'b000, vd};
      if (vd == ovf_code) begin
        b_side_next.base = RGB_OVF;
      end else if (vd == sat_code) begin
        b_side_next.base = RGB_SAT;
      end else if (vd == intf_code || vd == '0) begin
        b_side_next.base = RGB_BLACK;
      end else if (vd > range_max) begin
        b_side_next.base = RGB_MAGENTA;
      end else begin
        // Rainbow: the segment stage picks the channel.
        b_side_next.slot = SLOT_RED;
      end
    end else begin
      if (a_pix == sat_code) begin
        b_side_next.base = RGB_SAT;
      end else if (a_pix == ovf_code) begin
        b_side_next.base = RGB_OVF;
      end else if (a_pix > GRAY_TOP) begin
        b_side_next.base = RGB_WHITE;
      end else begin
        b_side_next.base = '{r: a_pix[CH_W-1:0], g: a_pix[CH_W-1:0],
                             b: a_pix[CH_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_side <= b_side_next;
      b_f    <= b_f_next;
    end
  end

  // Stage C: rainbow segment select and segment offset n, with n <= range_max.
  dpc_side_t        c_side, c_side_next;
  logic [PIX_W-1:0] c_n, c_n_next;

  always_comb begin
    logic [F_W-1:0] r1, r2, r3, r4, n_wide;
    r1          = {3'b000, range_max};
    r2          = r1 << 1;
    r4          = r1 << 2;
    r3          = r2 + r1;
    c_side_next = b_side;
    n_wide      = '0;
    if (b_side.slot != SLOT_NONE) begin
      if (b_f > r4) begin
        n_wide           = b_f - r4;
        c_side_next.slot = SLOT_RED;
        c_side_next.base = RGB_BLUE;
      end else if (b_f > r3) begin
        n_wide           = r4 - b_f;
        c_side_next.slot = SLOT_GREEN;
        c_side_next.base = RGB_BLUE;
      end else if (b_f > r2) begin
        n_wide           = b_f - r2;
        c_side_next.slot = SLOT_BLUE;
        c_side_next.base = RGB_GREEN;
      end else if (b_f > r1) begin
        n_wide           = r2 - b_f;
        c_side_next.slot = SLOT_RED;
        c_side_next.base = RGB_GREEN;
      end else begin
        n_wide           = b_f;
        c_side_next.slot = SLOT_GREEN;
        c_side_next.base = RGB_RED;
      end
    end
    c_n_next = n_wide[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (c_adv && b_valid) begin
      c_side <= c_side_next;
      c_n    <= c_n_next;
    end
  end

  // Stage D: scale the offset by 255.
  dpc_side_t        d_side;
  logic [NUM_W-1:0] d_num;

  always_ff @(posedge clk) begin
    if (d_adv && c_valid) begin
      d_side <= c_side;
      d_num  <= {c_n, {CH_W{1'b0}}} - {{CH_W{1'b0}}, c_n};
    end
  end

  // Divider: floor(255 * n / range_max), one bit per stage.
  logic [CH_W-1:0] div_quo;
  dpc_side_t       div_side;

  dpc_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (PIX_W),
    .Q_W   (CH_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (div_in_ready),
    .in_num    (d_num),
    .in_den    (range_max),
    .in_side   (d_side),
    .out_valid (div_out_valid),
    .out_ready (e_adv),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Stage E: place the quotient in its channel and hold the result.
  rgb_t e_rgb_next;

  always_comb begin
    e_rgb_next = div_side.base;
    case (div_side.slot)
      SLOT_NONE:  e_rgb_next = div_side.base;
      SLOT_RED:   e_rgb_next.r = div_quo;
      SLOT_GREEN: e_rgb_next.g = div_quo;
      SLOT_BLUE:  e_rgb_next.b = div_quo;
      default:    e_rgb_next = div_side.base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_adv && div_out_valid) begin
      red         <= e_rgb_next.r;
      green       <= e_rgb_next.g;
      blue        <= e_rgb_next.b;
      point_valid <= div_side.pv;
    end
  end

  assign out_valid = e_valid;

endmodule
